FILE: design/stfo_pkg.sv
// shared types and constants for the sleep timer fade-out block
package stfo_pkg;

    // field widths
    localparam int TPM_W  = 10;
    localparam int FADE_W = 16;
    localparam int VOL_W  = 16;
    localparam int MIN_W  = 10;
    localparam int REM_W  = 20;

    // shared divider: dividend holds a signed 17 x 20 product magnitude
    localparam int DIV_W = 37;
    localparam int DVS_W = 16;
    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] ITER_FADE = CNT_W'(DIV_W);
    localparam logic [CNT_W-1:0] ITER_MREM = CNT_W'(REM_W + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_TPM   = 2'd0;
    localparam logic [1:0] CFG_FADE  = 2'd1;
    localparam logic [1:0] CFG_MUTE  = 2'd2;
    localparam logic [1:0] CFG_DEFVOL = 2'd3;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // reset values
    localparam logic [TPM_W-1:0]  TPM_RST    = 10'd120;
    localparam logic [FADE_W-1:0] FADE_RST   = 16'd120;
    localparam logic [VOL_W-1:0]  MUTE_RST   = 16'hE200;
    localparam logic [VOL_W-1:0]  DEFVOL_RST = 16'hF600;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] iters;
    } t_div_ctl;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_MUL     = 7'b0000010,
        S_MRES    = 7'b0000100,
        S_FDIV    = 7'b0001000,
        S_MDSTART = 7'b0010000,
        S_MDIV    = 7'b0100000,
        S_DONE    = 7'b1000000
    } t_state;

endpackage

FILE: design/sleep_timer_fade_out.sv
// sleep timer with linear volume fade-out: sequencer, state and output register
//
// input channel: i_in_valid / o_in_stall carry one beat per command (tick or
// set). output channel: o_out_valid / i_out_stall carry one result beat per
// input beat, in order. configuration: i_cfg_we with i_cfg_idx selecting
// ticks_per_minute, fade_ticks, mute_level or default_volume.
// one beat is handled at a time; o_in_stall is high from acceptance until the
// result is moved into the output register. a single multiplier and one
// restoring divider (one quotient bit per cycle) do all the arithmetic.
// steps per beat, from acceptance until the result is in the output register:
//   idle tick, cancel, or firing tick: straight to the result
//   tick outside the fade window: 21-bit minutes-left divide
//   set: multiply, then minutes-left divide (no divide if ticks_per_minute is 0)
//   tick in the fade window: multiply, 37-bit fade divide,
//   then the minutes-left divide
// the next beat is accepted in the cycle after the result is registered,
// even while that result still waits for the receiver.
// reset (synchronous, active low) idles the timer, restores the register
// defaults and empties the output register; o_in_stall is high during reset.
// a receiver stall holds the output beat; a finished result then waits in
// the sequencer until the output register frees up.
module sleep_timer_fade_out (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [9:0]  i_minutes,
    input  logic signed [15:0] i_current_volume,
    input  logic        i_volume_known,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_volume_write,
    output logic signed [15:0] o_volume,
    output logic        o_save_write,
    output logic signed [15:0] o_saved_volume,
    output logic        o_standby,
    output logic        o_active,
    output logic        o_fading,
    output logic [9:0]  o_mins_left,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import stfo_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [TPM_W-1:0]  r_tpm;
    logic [FADE_W-1:0] r_fade;
    logic [VOL_W-1:0]  r_mute;
    logic [VOL_W-1:0]  r_defvol;

    // timer state
    logic [REM_W-1:0] r_rem;
    logic [VOL_W-1:0] r_held;
    logic             r_running;
    logic             r_in_fade;

    // working result of the current beat
    logic             r_vw;
    logic [VOL_W-1:0] r_vol;
    logic             r_sw;
    logic [VOL_W-1:0] r_sav;
    logic             r_sb;
    logic [MIN_W-1:0] r_mrem;

    // arithmetic operands and intermediates
    logic [MIN_W-1:0] r_minutes;
    logic             r_is_fade;
    logic [VOL_W:0]   r_diff;
    logic [DIV_W-1:0] r_prod;
    logic             r_neg;

    // output register
    logic             r_ovalid;
    logic             r_o_vw;
    logic [VOL_W-1:0] r_o_vol;
    logic             r_o_sw;
    logic [VOL_W-1:0] r_o_sav;
    logic             r_o_sb;
    logic             r_o_active;
    logic             r_o_fading;
    logic [MIN_W-1:0] r_o_mrem;

    logic             w_accept;
    logic             w_out_free;
    logic [REM_W-1:0] w_rem_dec;
    logic             w_fire;
    logic             w_in_window;
    logic signed [VOL_W:0]   w_mul_a;
    logic signed [REM_W:0]   w_mul_b;
    logic signed [DIV_W:0]   w_mul_p;
    logic [DIV_W-1:0] w_mag;
    logic [REM_W:0]   w_mnum;
    logic [VOL_W+1:0] w_q;
    logic [VOL_W+1:0] w_sq;
    logic [VOL_W+1:0] w_fvol;

    t_div_ctl         w_div_ctl;
    logic [DIV_W-1:0] w_div_dividend;
    logic [DVS_W-1:0] w_div_divisor;
    logic             w_div_done;
    logic [DIV_W-1:0] w_div_quo;

    assign w_accept   = i_in_valid && (r_state == S_IDLE) && i_rst_n;
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign w_out_free = !r_ovalid || !i_out_stall;

    // tick decisions on the count before this beat
    assign w_rem_dec   = r_rem - 1'b1;
    assign w_fire      = r_rem <= REM_W'(1);
    assign w_in_window = w_rem_dec < {{(REM_W-FADE_W){1'b0}}, r_fade};

    // shared multiplier: minutes x ticks_per_minute, or (held - mute) x ticks left
    assign w_mul_a = r_is_fade ? $signed(r_diff)
                               : $signed({{(VOL_W+1-MIN_W){1'b0}}, r_minutes});
    assign w_mul_b = r_is_fade ? $signed({1'b0, r_rem})
                               : $signed({{(REM_W+1-TPM_W){1'b0}}, r_tpm});
    assign w_mul_p = w_mul_a * w_mul_b;

    // fade divide works on the magnitude, sign is put back afterwards
    assign w_mag  = r_prod[DIV_W-1] ? (~r_prod + 1'b1) : r_prod;
    // ceil(rem / tpm) as floor((rem + tpm - 1) / tpm)
    assign w_mnum = {1'b0, r_rem} + {{(REM_W+1-TPM_W){1'b0}}, r_tpm} - 1'b1;

    assign w_q    = {1'b0, w_div_quo[VOL_W:0]};
    assign w_sq   = r_neg ? (~w_q + 1'b1) : w_q;
    assign w_fvol = {{2{r_mute[VOL_W-1]}}, r_mute} + w_sq;

    always_comb begin
        w_div_ctl.start = ((r_state == S_MRES) && r_is_fade)
                       || ((r_state == S_MDSTART) && (r_tpm != '0));
        if (r_state == S_MRES) begin
            w_div_ctl.iters = ITER_FADE;
            w_div_dividend  = w_mag;
            w_div_divisor   = r_fade;
        end else begin
            w_div_ctl.iters = ITER_MREM;
            w_div_dividend  = {w_mnum, {(DIV_W-REM_W-1){1'b0}}};
            w_div_divisor   = {{(DVS_W-TPM_W){1'b0}}, r_tpm};
        end
    end

    stfo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_SET) begin
                        n_state = (i_minutes != '0) ? S_MUL : S_DONE;
                    end else if (!r_running || w_fire) begin
                        n_state = S_DONE;
                    end else if (w_in_window) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_MDSTART;
                    end
                end
            end
            S_MUL:     n_state = S_MRES;
            S_MRES:    n_state = r_is_fade ? S_FDIV : S_MDSTART;
            S_FDIV:    n_state = w_div_done ? S_MDSTART : S_FDIV;
            S_MDSTART: n_state = (r_tpm == '0) ? S_DONE : S_MDIV;
            S_MDIV:    n_state = w_div_done ? S_DONE : S_MDIV;
            S_DONE:    n_state = w_out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tpm     <= TPM_RST;
            r_fade    <= FADE_RST;
            r_mute    <= MUTE_RST;
            r_defvol  <= DEFVOL_RST;
            r_rem     <= '0;
            r_held    <= DEFVOL_RST;
            r_running <= 1'b0;
            r_in_fade <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TPM:    r_tpm    <= i_cfg_data[TPM_W-1:0];
                    CFG_FADE:   r_fade   <= i_cfg_data[FADE_W-1:0];
                    CFG_MUTE:   r_mute   <= i_cfg_data;
                    CFG_DEFVOL: r_defvol <= i_cfg_data;
                    default:    ;
                endcase
            end

            if (w_accept) begin
                if (i_command == CMD_SET) begin
                    // cancel, then arm if minutes given
                    r_in_fade <= 1'b0;
                    r_rem     <= '0;
                    r_running <= (i_minutes != '0);
                    if (i_minutes != '0) begin
                        r_held <= i_volume_known ? i_current_volume : r_defvol;
                    end
                end else if (r_running) begin
                    if (w_fire) begin
                        r_rem     <= '0;
                        r_running <= 1'b0;
                        r_in_fade <= 1'b0;
                    end else begin
                        r_rem <= w_rem_dec;
                        if (w_in_window) begin
                            r_in_fade <= 1'b1;
                        end
                    end
                end
            end

            // armed count comes out of the multiplier
            if ((r_state == S_MRES) && !r_is_fade) begin
                r_rem <= r_prod[REM_W-1:0];
            end

            if ((r_state == S_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working result and arithmetic intermediates
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_minutes <= i_minutes;
                    r_is_fade <= (i_command == CMD_TICK);
                    r_diff    <= {r_held[VOL_W-1], r_held} - {r_mute[VOL_W-1], r_mute};
                    r_vw      <= 1'b0;
                    r_vol     <= '0;
                    r_sw      <= 1'b0;
                    r_sav     <= '0;
                    r_sb      <= 1'b0;
                    r_mrem    <= '0;
                    if (i_command == CMD_SET) begin
                        // restore the captured volume if a fade was under way
                        if (r_running && r_in_fade) begin
                            r_vw  <= 1'b1;
                            r_vol <= r_held;
                            r_sw  <= 1'b1;
                            r_sav <= r_held;
                        end
                    end else if (r_running) begin
                        if (w_fire) begin
                            r_vw  <= 1'b1;
                            r_vol <= r_mute;
                            r_sb  <= 1'b1;
                            r_sw  <= 1'b1;
                            r_sav <= r_held;
                        end else if (w_in_window) begin
                            r_vw <= 1'b1;
                        end
                    end
                end
            end
            S_MUL: begin
                r_prod <= w_mul_p[DIV_W-1:0];
            end
            S_MRES: begin
                r_neg <= r_prod[DIV_W-1];
            end
            S_FDIV: begin
                if (w_div_done) begin
                    r_vol <= w_fvol[VOL_W-1:0];
                end
            end
            S_MDIV: begin
                if (w_div_done) begin
                    r_mrem <= w_div_quo[MIN_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_o_vw     <= r_vw;
            r_o_vol    <= r_vol;
            r_o_sw     <= r_sw;
            r_o_sav    <= r_sav;
            r_o_sb     <= r_sb;
            r_o_active <= r_running;
            r_o_fading <= r_running && r_in_fade;
            r_o_mrem   <= r_mrem;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_volume_write = r_o_vw;
    assign o_volume       = r_o_vol;
    assign o_save_write   = r_o_sw;
    assign o_saved_volume = r_o_sav;
    assign o_standby      = r_o_sb;
    assign o_active       = r_o_active;
    assign o_fading       = r_o_fading;
    assign o_mins_left    = r_o_mrem;

endmodule

FILE: design/stfo_div.sv
// restoring divider, one quotient bit per cycle, shared by both divisions
module stfo_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  stfo_pkg::t_div_ctl           i_ctl,
    input  logic [stfo_pkg::DIV_W-1:0]   i_dividend,
    input  logic [stfo_pkg::DVS_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [stfo_pkg::DIV_W-1:0]   o_quotient
);
    import stfo_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0] w_shift;
    logic [DVS_W:0] w_diff;
    logic           w_ge;

    // shift in the next dividend bit and try the subtract
    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: design/stfo_chk.sv
// port-level assertions for the sleep timer, bound to the top level
module stfo_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_volume_write,
    input logic [15:0] o_volume,
    input logic        o_save_write,
    input logic        o_standby,
    input logic        o_active,
    input logic        o_fading,
    input logic [9:0]  o_mins_left
);

    // a firing beat writes the volume, persists and leaves the timer idle
    a_fire_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_standby |->
            o_volume_write && o_save_write && !o_active && !o_fading)
        else $error("standby beat without mute, save or idle");

    // fading only inside a running countdown
    a_fade_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fading |-> o_active)
        else $error("fading reported while not active");

    // idle reports no minutes left
    a_idle_mrem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_active |-> o_mins_left == 10'd0)
        else $error("minutes left reported while idle");

    // one beat at a time: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_volume))
        else $error("stalled output beat changed");

endmodule

bind sleep_timer_fade_out stfo_chk u_stfo_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_volume_write (o_volume_write),
    .o_volume       (o_volume),
    .o_save_write   (o_save_write),
    .o_standby      (o_standby),
    .o_active       (o_active),
    .o_fading       (o_fading),
    .o_mins_left    (o_mins_left)
);

FILE: tb/sv/tb_sleep_timer_fade_out.sv
// self-checking testbench for the sleep timer fade-out block
module tb_sleep_timer_fade_out;
    import stfo_pkg::*;

    localparam int PHASES     = 10;
    localparam int PER_PHASE  = 193;   // random beats per settings phase
    localparam int SETTLE_CYC = 70;    // settle time, longer than the longest beat
    localparam int HOLD_CYC   = 400;   // long receiver hold-off
    localparam int WATCHDOG   = 4000;  // cycles with no beat on either side

    // one input beat and one result beat, fields at the block's widths
    typedef struct packed {
        logic       cmd;
        logic [9:0] minutes;
        logic [15:0] vol;
        logic       known;
    } beat_t;

    typedef struct packed {
        logic        volume_write;
        logic [15:0] volume;
        logic        save_write;
        logic [15:0] saved_volume;
        logic        standby;
        logic        active;
        logic        fading;
        logic [9:0]  mins_left;
    } result_t;

    // a row of the directed script: a register write or a beat
    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [15:0] data;
        beat_t       b;
        bit          typed;
        result_t     want;
    } step_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_command = CMD_TICK;
    logic [9:0]         i_minutes = '0;
    logic signed [15:0] i_current_volume = '0;
    logic               i_volume_known = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_volume_write;
    logic signed [15:0] o_volume;
    logic               o_save_write;
    logic signed [15:0] o_saved_volume;
    logic               o_standby;
    logic               o_active;
    logic               o_fading;
    logic [9:0]         o_mins_left;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = CFG_TPM;
    logic [15:0]        i_cfg_data = '0;

    sleep_timer_fade_out dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the registers and the countdown
    int cfg_tpm    = int'(TPM_RST);
    int cfg_fade   = int'(FADE_RST);
    int cfg_mute   = int'($signed(MUTE_RST));
    int cfg_defvol = int'($signed(DEFVOL_RST));
    int tm_left    = 0;
    int tm_held    = int'($signed(DEFVOL_RST));
    bit tm_run     = 1'b0;
    bit tm_fade    = 1'b0;

    result_t expected_q[$];
    step_t   script[$];

    int errs = 0;
    int beats_counted = 0;
    int results_checked = 0;
    int n_fade = 0;
    int n_fire = 0;
    int n_restore = 0;

    bit tx_quiet = 1'b0;   // sender draws no gaps
    bit rx_quiet = 1'b0;   // receiver draws no stalls
    bit hold_req = 1'b0;
    bit rx_hold  = 1'b0;
    int rx_wait  = 0;
    int quiet_cycles = 0;

    // advance the countdown by one beat and return the result it yields
    function automatic result_t timer_advance(beat_t b);
        result_t r;
        longint  span;
        r = '0;
        if (b.cmd == CMD_SET) begin
            // cancelling a fading countdown puts the captured volume back
            if (tm_run && tm_fade) begin
                r.volume_write = 1'b1;
                r.volume       = 16'(tm_held);
                r.save_write   = 1'b1;
                r.saved_volume = 16'(tm_held);
                n_restore++;
            end
            tm_run  = 1'b0;
            tm_fade = 1'b0;
            tm_left = 0;
            if (b.minutes != '0) begin
                tm_held = b.known ? int'($signed(b.vol)) : cfg_defvol;
                tm_left = (int'(b.minutes) * cfg_tpm) & 'hFFFFF;
                tm_run  = 1'b1;
            end
        end else if (tm_run) begin
            if (tm_left <= 1) begin
                // timer fires: mute, standby, persist the captured volume
                tm_left        = 0;
                r.volume_write = 1'b1;
                r.volume       = 16'(cfg_mute);
                r.standby      = 1'b1;
                r.save_write   = 1'b1;
                r.saved_volume = 16'(tm_held);
                tm_run         = 1'b0;
                tm_fade        = 1'b0;
                n_fire++;
            end else begin
                tm_left--;
                if (tm_left < cfg_fade) begin
                    // linear ramp, quotient truncated toward zero
                    span = (longint'(tm_held) - longint'(cfg_mute)) * longint'(tm_left)
                           / longint'(cfg_fade);
                    tm_fade        = 1'b1;
                    r.volume_write = 1'b1;
                    r.volume       = 16'(longint'(cfg_mute) + span);
                    n_fade++;
                end
            end
        end
        if (tm_run && cfg_tpm != 0)
            r.mins_left = 10'((tm_left + cfg_tpm - 1) / cfg_tpm);
        r.active = tm_run;
        r.fading = tm_run && tm_fade;
        return r;
    endfunction

    function automatic result_t res(bit vw, int vol, bit sw, int sav, bit sb,
                                    bit act, bit fad, int mrem);
        result_t r;
        r = '{vw, 16'(vol), sw, 16'(sav), sb, act, fad, 10'(mrem)};
        return r;
    endfunction

    function automatic beat_t beat_of(logic cmd, int minutes, int vol, bit known);
        beat_t b;
        b = '{cmd, 10'(minutes), 16'(vol), known};
        return b;
    endfunction

    function automatic beat_t rand_beat(logic cmd, int minutes);
        return beat_of(cmd, minutes, int'($urandom), 1'($urandom_range(0, 1)));
    endfunction

    function automatic step_t row_beat(beat_t b);
        step_t s;
        s = '{1'b0, CFG_TPM, 16'd0, b, 1'b0, '0};
        return s;
    endfunction

    function automatic step_t row_check(beat_t b, result_t want);
        step_t s;
        s = '{1'b0, CFG_TPM, 16'd0, b, 1'b1, want};
        return s;
    endfunction

    function automatic step_t row_cfg(logic [1:0] idx, int data);
        step_t s;
        s = '{1'b1, idx, 16'(data), '0, 1'b0, '0};
        return s;
    endfunction

    task automatic chk(string fld, int e, int a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, e, a);
            errs++;
        end
    endtask

    // offer one beat, wait for it to be taken, queue its expected result
    task automatic send_beat(beat_t b, bit typed, result_t want);
        int      gap;
        result_t r;
        gap = tx_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_command        <= b.cmd;
        i_minutes        <= b.minutes;
        i_current_volume <= b.vol;
        i_volume_known   <= b.known;
        do @(posedge i_clk); while (o_in_stall);
        beats_counted++;
        r = timer_advance(b);
        expected_q.push_back(typed ? want : r);
    endtask

    // stop offering, wait for every result, then let the block go quiet
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TPM:    cfg_tpm    = int'(data[9:0]);
            CFG_FADE:   cfg_fade   = int'(data);
            CFG_MUTE:   cfg_mute   = int'($signed(data));
            CFG_DEFVOL: cfg_defvol = int'($signed(data));
            default: ;
        endcase
    endtask

    // receiver: random stall per beat, plus the long hold-off when asked
    always @(posedge i_clk) begin
        result_t want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    results_checked++;
                    chk("volume_write", want.volume_write, o_volume_write);
                    chk("volume", int'($signed(want.volume)), int'(o_volume));
                    chk("save_write", want.save_write, o_save_write);
                    chk("saved_volume", int'($signed(want.saved_volume)),
                        int'(o_saved_volume));
                    chk("standby", want.standby, o_standby);
                    chk("active", want.active, o_active);
                    chk("fading", want.fading, o_fading);
                    chk("mins_left", want.mins_left, o_mins_left);
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 15);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            i_out_stall <= rx_hold || (rx_wait != 0);
        end
    end

    // long hold-off, counted here while the sender keeps offering
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // watchdog: no beat moving on either channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int ph;
        int sel;
        int mins;
        int span;
        int n;
        int stop_at;

        // directed part, reset settings first
        script.push_back(row_check(beat_of(CMD_TICK, 0, 0, 1'b1), res(0, 0, 0, 0, 0, 0, 0, 0)));
        script.push_back(row_check(beat_of(CMD_SET, 0, 100, 1'b1),
                                   res(0, 0, 0, 0, 0, 0, 0, 0)));
        script.push_back(row_check(beat_of(CMD_SET, 1, 32767, 1'b1),
                                   res(0, 0, 0, 0, 0, 1, 0, 1)));
        // re-arm while running but not fading: no restore; longest count
        script.push_back(row_check(beat_of(CMD_SET, 1023, -32768, 1'b0),
                                   res(0, 0, 0, 0, 0, 1, 0, 1023)));
        script.push_back(row_beat(beat_of(CMD_TICK, 1023, 0, 1'b0)));
        script.push_back(row_check(beat_of(CMD_SET, 0, 0, 1'b0),
                                   res(0, 0, 0, 0, 0, 0, 0, 0)));
        // one tick per minute, short fade, volume extremes
        script.push_back(row_cfg(CFG_TPM, 1));
        script.push_back(row_cfg(CFG_FADE, 4));
        script.push_back(row_cfg(CFG_MUTE, -32768));
        script.push_back(row_cfg(CFG_DEFVOL, 32767));
        script.push_back(row_check(beat_of(CMD_SET, 5, 32767, 1'b1),
                                   res(0, 0, 0, 0, 0, 1, 0, 5)));
        repeat (4) script.push_back(row_beat(beat_of(CMD_TICK, 0, 0, 1'b0)));
        // count at one: fires without a ramp value
        script.push_back(row_check(beat_of(CMD_TICK, 0, 0, 1'b0),
                                   res(1, -32768, 1, 32767, 1, 0, 0, 0)));
        script.push_back(row_check(beat_of(CMD_TICK, 0, 0, 1'b0),
                                   res(0, 0, 0, 0, 0, 0, 0, 0)));
        // unknown volume takes the default
        script.push_back(row_check(beat_of(CMD_SET, 5, -32768, 1'b0),
                                   res(0, 0, 0, 0, 0, 1, 0, 5)));
        repeat (3) script.push_back(row_beat(beat_of(CMD_TICK, 1023, -1, 1'b1)));
        // re-arm mid-fade restores the captured volume first
        script.push_back(row_check(beat_of(CMD_SET, 3, -32768, 1'b1),
                                   res(1, 32767, 1, 32767, 0, 1, 0, 3)));
        script.push_back(row_beat(beat_of(CMD_TICK, 0, 0, 1'b0)));
        // cancel mid-fade
        script.push_back(row_check(beat_of(CMD_SET, 0, 0, 1'b1),
                                   res(1, -32768, 1, -32768, 0, 0, 0, 0)));
        // zero ticks per minute: arms at zero, next tick fires
        script.push_back(row_cfg(CFG_TPM, 0));
        script.push_back(row_check(beat_of(CMD_SET, 7, 'h1234, 1'b1),
                                   res(0, 0, 0, 0, 0, 1, 0, 0)));
        script.push_back(row_check(beat_of(CMD_TICK, 0, 0, 1'b0),
                                   res(1, -32768, 1, 'h1234, 1, 0, 0, 0)));
        // widest count, no fade window
        script.push_back(row_cfg(CFG_TPM, 1023));
        script.push_back(row_cfg(CFG_FADE, 0));
        script.push_back(row_beat(beat_of(CMD_SET, 1023, 0, 1'b1)));
        script.push_back(row_beat(beat_of(CMD_TICK, 0, 0, 1'b1)));
        script.push_back(row_check(beat_of(CMD_SET, 0, 0, 1'b1),
                                   res(0, 0, 0, 0, 0, 0, 0, 0)));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                drain_results();
                cfg_write(script[k].idx, script[k].data);
            end else begin
                send_beat(script[k].b, script[k].typed, script[k].want);
            end
        end

        // random part, one settings phase at a time
        for (ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0: begin
                    cfg_write(CFG_TPM, 16'd1);
                    cfg_write(CFG_FADE, 16'd1);
                    cfg_write(CFG_MUTE, 16'h8000);
                    cfg_write(CFG_DEFVOL, 16'h7FFF);
                end
                1: begin
                    cfg_write(CFG_TPM, 16'd2);
                    cfg_write(CFG_FADE, 16'hFFFF);
                    cfg_write(CFG_MUTE, 16'h7FFF);
                    cfg_write(CFG_DEFVOL, 16'h8000);
                end
                2: begin
                    cfg_write(CFG_TPM, 16'd0);
                    cfg_write(CFG_FADE, 16'($urandom_range(1, 30)));
                    cfg_write(CFG_MUTE, 16'($urandom));
                    cfg_write(CFG_DEFVOL, 16'($urandom));
                end
                3: begin
                    cfg_write(CFG_TPM, 16'd1023);
                    cfg_write(CFG_FADE, 16'd0);
                    cfg_write(CFG_MUTE, 16'($urandom));
                    cfg_write(CFG_DEFVOL, 16'($urandom));
                end
                default: begin
                    cfg_write(CFG_TPM, 16'($urandom_range(1, 6)));
                    cfg_write(CFG_FADE, ($urandom_range(0, 7) == 0) ? 16'd0
                                        : 16'($urandom_range(1, 30)));
                    cfg_write(CFG_MUTE, 16'($urandom));
                    cfg_write(CFG_DEFVOL, 16'($urandom));
                end
            endcase
            // back-to-back stretches; phase 4 also fills the block behind a hold
            tx_quiet = (ph == 3 || ph == 4 || ph == 6);
            rx_quiet = (ph == 3 || ph == 6);
            if (ph == 4)
                hold_req = 1'b1;
            stop_at = beats_counted + PER_PHASE;
            while (beats_counted < stop_at) begin
                sel = $urandom_range(0, 99);
                if (sel < 72) begin
                    // arm, then tick through the fade to the firing, or cut it short
                    mins = (cfg_tpm > 8) ? $urandom_range(1, 2) : $urandom_range(1, 4);
                    send_beat(rand_beat(CMD_SET, mins), 1'b0, '0);
                    span = (tm_left > 0) ? tm_left : 1;
                    if (span <= 40 && $urandom_range(0, 9) < 7)
                        n = span + $urandom_range(0, 2);
                    else
                        n = $urandom_range(0, (span < 40) ? span : 40);
                    repeat (n) send_beat(rand_beat(CMD_TICK, int'($urandom)), 1'b0, '0);
                end else if (sel < 84) begin
                    send_beat(rand_beat(CMD_SET, $urandom_range(0, 1023)), 1'b0, '0);
                    repeat ($urandom_range(0, 3))
                        send_beat(rand_beat(CMD_TICK, int'($urandom)), 1'b0, '0);
                end else if (sel < 92) begin
                    send_beat(rand_beat(CMD_SET, 0), 1'b0, '0);
                end else begin
                    repeat ($urandom_range(1, 3))
                        send_beat(rand_beat(CMD_TICK, int'($urandom)), 1'b0, '0);
                end
            end
        end

        drain_results();
        if (expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_q.size());
            errs++;
        end
        $display("tb: %0d input beats, %0d results checked over %0d settings phases",
                 beats_counted, results_checked, PHASES);
        $display("tb: %0d ramp steps, %0d timer expiries, %0d restores on cancel, %0d errors",
                 n_fade, n_fire, n_restore, errs);
        if (errs == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
design/stfo_pkg.sv
design/stfo_div.sv
design/sleep_timer_fade_out.sv
design/stfo_chk.sv
tb/sv/tb_sleep_timer_fade_out.sv
